// File: sv/x25519_scalar_multiply_defines.svh
// ---------------------------------------------------------------------------
// x25519_scalar_multiply_defines.svh
// Assertion macros shared by the X25519 block.
// ---------------------------------------------------------------------------
`ifndef X25519_SCALAR_MULTIPLY_DEFINES_SVH
`define X25519_SCALAR_MULTIPLY_DEFINES_SVH

// same-cycle implication, checked outside reset
`define X25_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define X25_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/x25_pkg.sv
// ---------------------------------------------------------------------------
// x25_pkg
// Shared constants, codes, control structs and the microcode program.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package x25_pkg;

  // p = 2^255 - 19
  localparam logic [255:0] P     = {1'b0, {247{1'b1}}, 8'hED};
  localparam logic [257:0] FOURP = {P, 2'b00};

  localparam logic [7:0]  CLAMP_LO      = 8'hF8;
  localparam logic [7:0]  CLAMP_HI_KEEP = 8'h7F;
  localparam logic [7:0]  CLAMP_HI_SET  = 8'h40;
  localparam logic [7:0]  RESET_POS     = 8'd254;
  // exponent p-2 has zero bits at positions two and four
  localparam logic [7:0]  SKIP_BIT_A    = 8'd2;
  localparam logic [7:0]  SKIP_BIT_B    = 8'd4;
  localparam logic [16:0] A24           = 17'd121665;
  localparam logic [1:0]  LAST_WORD     = 2'd3;

  // register file slots; the first four take part in the ladder swap
  localparam logic [3:0] R_X2 = 4'd0;
  localparam logic [3:0] R_Z2 = 4'd1;
  localparam logic [3:0] R_X3 = 4'd2;
  localparam logic [3:0] R_Z3 = 4'd3;
  localparam logic [3:0] R_X1 = 4'd4;
  localparam logic [3:0] R_A  = 4'd5;
  localparam logic [3:0] R_AA = 4'd6;
  localparam logic [3:0] R_B  = 4'd7;
  localparam logic [3:0] R_BB = 4'd8;
  localparam logic [3:0] R_E  = 4'd9;
  localparam logic [3:0] R_C  = 4'd10;
  localparam logic [3:0] R_D  = 4'd11;
  localparam logic [3:0] R_DA = 4'd12;
  localparam logic [3:0] R_CB = 4'd13;
  localparam logic [3:0] R_K  = 4'd14;
  localparam logic [3:0] R_T  = 4'd15;

  localparam logic [4:0] PC_LADDER  = 5'd6;
  localparam logic [4:0] PC_INV     = 5'd25;
  localparam logic [4:0] PC_INV_END = 5'd27;

  typedef enum logic [2:0] {
    OP_NOP, OP_CONST, OP_LDU, OP_ADD, OP_SUB, OP_MUL, OP_CANON
  } op_t;

  typedef enum logic [1:0] {FL_NEXT, FL_LOOP, FL_SKIP, FL_END} flow_t;

  typedef enum logic [1:0] {WS_CONST, WS_POINT, WS_FU} wsel_t;

  typedef struct packed {
    op_t         op;
    logic        map;
    logic [3:0]  dst;
    logic [3:0]  sa;
    logic [3:0]  sb;
    logic [16:0] imm;
    flow_t       flow;
    logic [4:0]  target;
  } cw_t;

  typedef struct packed {
    logic        busy;
    logic [3:0]  rd_a;
    logic [3:0]  rd_b;
    logic        wr_en;
    logic [3:0]  wr_addr;
    wsel_t       wr_sel;
    logic [16:0] imm;
    logic        fu_start;
    op_t         fu_op;
    logic        done;
    logic [7:0]  pos;
  } ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } fu_stat_t;

  function automatic cw_t mk(input op_t op, input logic map, input logic [3:0] dst,
                             input logic [3:0] sa, input logic [3:0] sb,
                             input logic [16:0] imm, input flow_t flow,
                             input logic [4:0] target);
    cw_t w;
    w.op     = op;
    w.map    = map;
    w.dst    = dst;
    w.sa     = sa;
    w.sb     = sb;
    w.imm    = imm;
    w.flow   = flow;
    w.target = target;
    return w;
  endfunction

  function automatic cw_t prog_word(input logic [4:0] pc);
    cw_t w;
    case (pc)
      // setup
      5'd0:  w = mk(OP_LDU,   1'b0, R_X1, R_X1, R_X1, 17'd0, FL_NEXT, 5'd0);
      5'd1:  w = mk(OP_LDU,   1'b0, R_X3, R_X1, R_X1, 17'd0, FL_NEXT, 5'd0);
      5'd2:  w = mk(OP_CONST, 1'b0, R_X2, R_X1, R_X1, 17'd1, FL_NEXT, 5'd0);
      5'd3:  w = mk(OP_CONST, 1'b0, R_Z2, R_X1, R_X1, 17'd0, FL_NEXT, 5'd0);
      5'd4:  w = mk(OP_CONST, 1'b0, R_Z3, R_X1, R_X1, 17'd1, FL_NEXT, 5'd0);
      5'd5:  w = mk(OP_CONST, 1'b0, R_K,  R_X1, R_X1, A24,   FL_NEXT, 5'd0);
      // ladder step
      5'd6:  w = mk(OP_ADD,   1'b1, R_A,  R_X2, R_Z2, 17'd0, FL_NEXT, 5'd0);
      5'd7:  w = mk(OP_MUL,   1'b1, R_AA, R_A,  R_A,  17'd0, FL_NEXT, 5'd0);
      5'd8:  w = mk(OP_SUB,   1'b1, R_B,  R_X2, R_Z2, 17'd0, FL_NEXT, 5'd0);
      5'd9:  w = mk(OP_MUL,   1'b1, R_BB, R_B,  R_B,  17'd0, FL_NEXT, 5'd0);
      5'd10: w = mk(OP_SUB,   1'b1, R_E,  R_AA, R_BB, 17'd0, FL_NEXT, 5'd0);
      5'd11: w = mk(OP_ADD,   1'b1, R_C,  R_X3, R_Z3, 17'd0, FL_NEXT, 5'd0);
      5'd12: w = mk(OP_SUB,   1'b1, R_D,  R_X3, R_Z3, 17'd0, FL_NEXT, 5'd0);
      5'd13: w = mk(OP_MUL,   1'b1, R_DA, R_D,  R_A,  17'd0, FL_NEXT, 5'd0);
      5'd14: w = mk(OP_MUL,   1'b1, R_CB, R_C,  R_B,  17'd0, FL_NEXT, 5'd0);
      5'd15: w = mk(OP_ADD,   1'b1, R_X3, R_DA, R_CB, 17'd0, FL_NEXT, 5'd0);
      5'd16: w = mk(OP_MUL,   1'b1, R_X3, R_X3, R_X3, 17'd0, FL_NEXT, 5'd0);
      5'd17: w = mk(OP_SUB,   1'b1, R_Z3, R_DA, R_CB, 17'd0, FL_NEXT, 5'd0);
      5'd18: w = mk(OP_MUL,   1'b1, R_Z3, R_Z3, R_Z3, 17'd0, FL_NEXT, 5'd0);
      5'd19: w = mk(OP_MUL,   1'b1, R_Z3, R_Z3, R_X1, 17'd0, FL_NEXT, 5'd0);
      5'd20: w = mk(OP_MUL,   1'b1, R_X2, R_AA, R_BB, 17'd0, FL_NEXT, 5'd0);
      5'd21: w = mk(OP_MUL,   1'b1, R_Z2, R_E,  R_K,  17'd0, FL_NEXT, 5'd0);
      5'd22: w = mk(OP_ADD,   1'b1, R_Z2, R_Z2, R_AA, 17'd0, FL_NEXT, 5'd0);
      5'd23: w = mk(OP_MUL,   1'b1, R_Z2, R_Z2, R_E,  17'd0, FL_LOOP, PC_LADDER);
      // inversion by square and multiply
      5'd24: w = mk(OP_CONST, 1'b0, R_T,  R_X1, R_X1, 17'd1, FL_NEXT, 5'd0);
      5'd25: w = mk(OP_MUL,   1'b0, R_T,  R_T,  R_T,  17'd0, FL_SKIP, PC_INV_END);
      5'd26: w = mk(OP_MUL,   1'b0, R_T,  R_T,  R_Z2, 17'd0, FL_NEXT, 5'd0);
      5'd27: w = mk(OP_NOP,   1'b0, R_T,  R_T,  R_T,  17'd0, FL_LOOP, PC_INV);
      // final product and reduction
      5'd28: w = mk(OP_MUL,   1'b0, R_T,  R_X2, R_T,  17'd0, FL_NEXT, 5'd0);
      5'd29: w = mk(OP_CANON, 1'b0, R_T,  R_T,  R_T,  17'd0, FL_END,  5'd0);
      default: w = mk(OP_NOP, 1'b0, R_T,  R_T,  R_T,  17'd0, FL_END,  5'd0);
    endcase
    return w;
  endfunction

endpackage

// File: sv/x25_rf.sv
// ---------------------------------------------------------------------------
// x25_rf
// 16 x 256-bit field element store, one write port, two registered reads.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module x25_rf (
  input  logic         clk,
  input  logic         we,
  input  logic [3:0]   wa,
  input  logic [255:0] wd,
  input  logic [3:0]   ra,
  input  logic [3:0]   rb,
  output logic [255:0] qa,
  output logic [255:0] qb
);

  logic [255:0] mem [16];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    qa <= mem[ra];
    qb <= mem[rb];
  end

endmodule

// File: sv/x25_fu.sv
// ---------------------------------------------------------------------------
// x25_fu
// Field unit mod 2^255-19: add, subtract, multiply (32x32 MAC, column
// order), canonical reduction. Values kept below 2^256 between ops.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module x25_fu (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  x25_pkg::op_t       op,
  input  logic [255:0]       a,
  input  logic [255:0]       b,
  output logic [255:0]       result,
  output x25_pkg::fu_stat_t  stat
);

  typedef enum logic [7:0] {
    F_IDLE  = 8'b0000_0001,
    F_ADD   = 8'b0000_0010,
    F_FOLD1 = 8'b0000_0100,
    F_FOLD2 = 8'b0000_1000,
    F_MUL   = 8'b0001_0000,
    F_RED   = 8'b0010_0000,
    F_CAN1  = 8'b0100_0000,
    F_CAN2  = 8'b1000_0000
  } fstate_t;

  fstate_t      state;
  logic         done;
  logic [255:0] ra, rb, lo, hi;
  logic [257:0] w;
  logic [69:0]  acc;
  logic [3:0]   k;
  logic [2:0]   i;
  logic [2:0]   cnt;

  logic [3:0]   j4, iend4, k_inc, ist4;
  logic [31:0]  opa, opb;
  logic [63:0]  prod;
  logic [69:0]  msum, rsum;
  logic         col_end;
  logic [255:0] lo_shift;
  logic         ge;

  always_comb begin
    j4       = k - {1'b0, i};
    iend4    = k[3] ? 4'd7 : k;
    k_inc    = k + 4'd1;
    ist4     = k_inc[3] ? (k_inc - 4'd7) : 4'd0;
    opa      = ra[{i, 5'd0} +: 32];
    opb      = rb[{j4[2:0], 5'd0} +: 32];
    prod     = opa * opb;
    // column 15 only carries the top word out
    msum     = acc + ((k == 4'd15) ? 70'd0 : {6'd0, prod});
    col_end  = (k == 4'd15) || ({1'b0, i} == iend4);
    // 2^256 == 38 mod p
    rsum     = acc + {38'd0, lo[31:0]} + (70'(hi[31:0]) * 70'd38);
    lo_shift = {rsum[31:0], lo[255:32]};
    ge       = (w[255:0] >= x25_pkg::P);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        F_IDLE: begin
          if (start) begin
            case (op)
              x25_pkg::OP_ADD:   state <= F_ADD;
              x25_pkg::OP_SUB:   state <= F_ADD;
              x25_pkg::OP_MUL:   state <= F_MUL;
              x25_pkg::OP_CANON: state <= F_CAN1;
              default:           state <= F_IDLE;
            endcase
          end
        end
        F_ADD:   state <= F_FOLD1;
        F_FOLD1: state <= F_FOLD2;
        F_FOLD2: begin
          state <= F_IDLE;
          done  <= 1'b1;
        end
        F_MUL: begin
          if (col_end && (k == 4'd15)) begin
            state <= F_RED;
          end
        end
        F_RED: begin
          if (cnt == 3'd7) begin
            state <= F_FOLD2;
          end
        end
        F_CAN1:  state <= F_CAN2;
        F_CAN2: begin
          state <= F_IDLE;
          done  <= 1'b1;
        end
        default: state <= F_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      F_IDLE: begin
        if (start) begin
          ra  <= a;
          rb  <= b;
          acc <= '0;
          k   <= '0;
          i   <= '0;
          cnt <= '0;
          if (op == x25_pkg::OP_SUB) begin
            w <= x25_pkg::FOURP - {2'b00, b};
          end else if (op == x25_pkg::OP_CANON) begin
            w <= {2'b00, a};
          end else begin
            w <= {2'b00, b};
          end
        end
      end
      F_ADD:   w <= {2'b00, ra} + w;
      F_FOLD1: w <= {2'b00, w[255:0]} + (258'(w[257:256]) * 258'd38);
      F_FOLD2: w <= {2'b00, w[255:0]} + (w[256] ? 258'd38 : 258'd0);
      F_MUL: begin
        if (col_end) begin
          if (k[3]) begin
            hi <= {msum[31:0], hi[255:32]};
          end else begin
            lo <= {msum[31:0], lo[255:32]};
          end
          acc <= msum >> 32;
          k   <= k_inc;
          i   <= ist4[2:0];
        end else begin
          acc <= msum;
          i   <= i + 3'd1;
        end
      end
      F_RED: begin
        lo  <= lo_shift;
        hi  <= {32'd0, hi[255:32]};
        acc <= rsum >> 32;
        cnt <= cnt + 3'd1;
        if (cnt == 3'd7) begin
          w <= {2'b00, lo_shift} + (258'(rsum[37:32]) * 258'd38);
        end
      end
      F_CAN1, F_CAN2: begin
        if (ge) begin
          w <= w - {2'b00, x25_pkg::P};
        end
      end
      default: ;
    endcase
  end

  assign result    = w[255:0];
  assign stat.busy = (state != F_IDLE);
  assign stat.done = done;

endmodule

// File: sv/x25_seq.sv
// ---------------------------------------------------------------------------
// x25_seq
// Microcode sequencer: program counter, bit position, ladder swap renaming.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module x25_seq (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              sbit,
  input  x25_pkg::fu_stat_t fu,
  output x25_pkg::ctl_t     ctl
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_RD   = 4'b0010,
    S_EX   = 4'b0100,
    S_WT   = 4'b1000
  } sstate_t;

  sstate_t         state;
  logic [4:0]      pc;
  logic [7:0]      pos;
  x25_pkg::cw_t    cw;
  logic            is_fu, swap, advance, fin;
  logic [4:0]      pc_next;
  logic [7:0]      pos_next;

  // swapping x2/x3 and z2/z3 is done by renaming slots
  function automatic logic [3:0] map_addr(input logic [3:0] ad, input logic sw);
    return (sw && (ad[3:2] == 2'b00)) ? (ad ^ 4'b0010) : ad;
  endfunction

  always_comb begin
    cw    = x25_pkg::prog_word(pc);
    is_fu = (cw.op == x25_pkg::OP_ADD) || (cw.op == x25_pkg::OP_SUB) ||
            (cw.op == x25_pkg::OP_MUL) || (cw.op == x25_pkg::OP_CANON);
    swap  = cw.map & sbit;
    advance = ((state == S_EX) && !is_fu) || ((state == S_WT) && fu.done);
    pc_next  = pc + 5'd1;
    pos_next = pos;
    fin      = 1'b0;
    case (cw.flow)
      x25_pkg::FL_LOOP: begin
        if (pos != 8'd0) begin
          pc_next  = cw.target;
          pos_next = pos - 8'd1;
        end else begin
          pos_next = x25_pkg::RESET_POS;
        end
      end
      x25_pkg::FL_SKIP: begin
        if ((pos == x25_pkg::SKIP_BIT_A) || (pos == x25_pkg::SKIP_BIT_B)) begin
          pc_next = cw.target;
        end
      end
      x25_pkg::FL_END: fin = 1'b1;
      default: ;
    endcase

    ctl.busy     = (state != S_IDLE);
    ctl.rd_a     = map_addr(cw.sa, swap);
    ctl.rd_b     = map_addr(cw.sb, swap);
    ctl.wr_addr  = map_addr(cw.dst, swap);
    ctl.wr_en    = ((state == S_EX) &&
                    ((cw.op == x25_pkg::OP_CONST) || (cw.op == x25_pkg::OP_LDU))) ||
                   ((state == S_WT) && fu.done);
    case (cw.op)
      x25_pkg::OP_CONST: ctl.wr_sel = x25_pkg::WS_CONST;
      x25_pkg::OP_LDU:   ctl.wr_sel = x25_pkg::WS_POINT;
      default:           ctl.wr_sel = x25_pkg::WS_FU;
    endcase
    ctl.imm      = cw.imm;
    ctl.fu_start = (state == S_EX) && is_fu;
    ctl.fu_op    = cw.op;
    ctl.done     = (state == S_WT) && fu.done && fin;
    ctl.pos      = pos;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pc    <= '0;
      pos   <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            pc    <= '0;
            pos   <= x25_pkg::RESET_POS;
            state <= S_RD;
          end
        end
        S_RD: state <= S_EX;
        S_EX, S_WT: begin
          if ((state == S_EX) && is_fu) begin
            state <= S_WT;
          end else if (advance) begin
            if (fin) begin
              state <= S_IDLE;
            end else begin
              pc    <= pc_next;
              pos   <= pos_next;
              state <= S_RD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: sv/x25519_scalar_multiply.sv
// ---------------------------------------------------------------------------
// x25519_scalar_multiply
// X25519 Montgomery-ladder scalar multiply over GF(2^255-19). Load the
// scalar and u-coordinate as four 64-bit words (word 0 first); the
// transaction with word index 3 starts the run, while words 0..2 are just
// stored. The scalar is clamped (low three bits and bit 255 cleared, bit
// 254 set) and bit 255 of u is ignored. A run is made of 255 ladder steps
// of ten multiplies and eight add/subtract ops, then 508 multiplies for
// the inversion, one more multiply and a final reduction. The field unit
// has a single 32x32 multiply-accumulate: a multiply runs 65
// multiply-accumulate steps, 8 reduction words and a fold, besides the
// microcode fetch. No input is taken while a run is in progress or while
// result words are waiting. The four result words then come out least
// significant first; all_zero is set on all four when the shared secret is
// zero (low-order input point).
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "x25519_scalar_multiply_defines.svh"

module x25519_scalar_multiply (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  word_index,
  input  logic [63:0] scalar_word,
  input  logic [63:0] point_word,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_index,
  output logic [63:0] out_word,
  output logic        is_last,
  output logic        all_zero
);

  // loaded words
  logic [63:0] scalar_store     [4];
  logic [63:0] base_point_store [4];

  x25_pkg::ctl_t     ctl;
  x25_pkg::fu_stat_t fu_stat;

  logic         in_fire, start;
  logic [255:0] sc_raw, sc_cl, point;
  logic         sbit;
  logic [255:0] rf_wd, rf_qa, rf_qb, fu_result;

  // output holding stage
  logic [255:0] res;
  logic         zero;
  logic         out_busy;
  logic [1:0]   cnt;

  assign in_ready = !ctl.busy && !out_busy;
  assign in_fire  = in_valid && in_ready;
  assign start    = in_fire && (word_index == x25_pkg::LAST_WORD);

  always_ff @(posedge clk) begin
    if (in_fire) begin
      scalar_store[word_index]     <= scalar_word;
      base_point_store[word_index] <= point_word;
    end
  end

  // clamp and pick the current ladder bit
  always_comb begin
    sc_raw = {scalar_store[3], scalar_store[2], scalar_store[1], scalar_store[0]};
    sc_cl  = sc_raw;
    sc_cl[7:0]     = sc_raw[7:0] & x25_pkg::CLAMP_LO;
    sc_cl[255:248] = (sc_raw[255:248] & x25_pkg::CLAMP_HI_KEEP) | x25_pkg::CLAMP_HI_SET;
    sbit   = sc_cl[ctl.pos];
    point  = {1'b0, base_point_store[3][62:0], base_point_store[2],
              base_point_store[1], base_point_store[0]};
  end

  always_comb begin
    case (ctl.wr_sel)
      x25_pkg::WS_CONST: rf_wd = {239'd0, ctl.imm};
      x25_pkg::WS_POINT: rf_wd = point;
      default:           rf_wd = fu_result;
    endcase
  end

  x25_seq u_seq (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sbit  (sbit),
    .fu    (fu_stat),
    .ctl   (ctl)
  );

  x25_rf u_rf (
    .clk (clk),
    .we  (ctl.wr_en),
    .wa  (ctl.wr_addr),
    .wd  (rf_wd),
    .ra  (ctl.rd_a),
    .rb  (ctl.rd_b),
    .qa  (rf_qa),
    .qb  (rf_qb)
  );

  x25_fu u_fu (
    .clk    (clk),
    .rst    (rst),
    .start  (ctl.fu_start),
    .op     (ctl.fu_op),
    .a      (rf_qa),
    .b      (rf_qb),
    .result (fu_result),
    .stat   (fu_stat)
  );

  // result words drain one per transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      out_busy <= 1'b0;
      cnt      <= '0;
    end else if (ctl.done) begin
      out_busy <= 1'b1;
      cnt      <= '0;
    end else if (out_valid && out_ready) begin
      cnt <= cnt + 2'd1;
      if (cnt == x25_pkg::LAST_WORD) begin
        out_busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.done) begin
      res  <= fu_result;
      zero <= (fu_result == 256'd0);
    end
  end

  assign out_valid = out_busy;
  assign out_index = cnt;
  assign out_word  = res[{cnt, 6'd0} +: 64];
  assign is_last   = (cnt == x25_pkg::LAST_WORD);
  assign all_zero  = zero;

  `X25_ASSERT_NXT(a_drain, out_valid && out_ready && is_last, !out_valid, "output not drained")
  `X25_ASSERT_IMP(a_no_overwrite, ctl.done, !out_busy, "result overwrote pending words")
  `X25_ASSERT_IMP(a_fu_free, ctl.fu_start, !fu_stat.busy, "field unit started while busy")
  `X25_ASSERT_NXT(a_first_word, ctl.done, out_valid && (out_index == 2'd0), "bad first word")

endmodule

// File: tb/sv/testbench.sv
// ---------------------------------------------------------------------------
// X25519 scalar multiply testbench
// Loads scalar and u-coordinate words through the input valid/ready channel
// and checks every result transaction against a modular-arithmetic Montgomery
// ladder that is computed when each start word (index 3) is accepted.
// Both channels stall at random.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

  typedef logic [255:0] gf_t;

  // one load transaction, plus a flag that holds it until all results drain
  typedef struct {
    logic [1:0]  idx;
    logic [63:0] scal;
    logic [63:0] pnt;
    bit          drain_first;
  } load_t;

  typedef struct {
    logic [1:0]  idx;
    logic [63:0] word;
    logic        last;
    logic        zero;
  } secret_word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  word_index = '0;
  logic [63:0] scalar_word = '0;
  logic [63:0] point_word = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_index;
  logic [63:0] out_word;
  logic        is_last;
  logic        all_zero;

  load_t        load_q[$];
  secret_word_t secret_q[$];
  logic [63:0]  scalar_copy[4];
  logic [63:0]  point_copy[4];
  int           errors = 0;
  bit           took = 0;
  int           send_gap = 0;
  int           recv_gap = 0;
  bit           no_stall = 0;

  x25519_scalar_multiply uut (
    .clk, .rst, .in_valid, .in_ready, .word_index, .scalar_word, .point_word,
    .out_valid, .out_ready, .out_index, .out_word, .is_last, .all_zero
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // --- field arithmetic mod p ---------------------------------------------
  function automatic gf_t gf_add(gf_t a, gf_t b);
    logic [256:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, x25_pkg::P}) s = s - {1'b0, x25_pkg::P};
    return s[255:0];
  endfunction

  function automatic gf_t gf_sub(gf_t a, gf_t b);
    if (a >= b) return a - b;
    return (a + x25_pkg::P) - b;
  endfunction

  function automatic gf_t gf_mul(gf_t a, gf_t b);
    logic [511:0] w;
    w = {256'b0, a} * {256'b0, b};
    w = w % {256'b0, x25_pkg::P};
    return w[255:0];
  endfunction

  // shared u-coordinate from the stored words (clamped scalar, masked u)
  function automatic gf_t x25519_shared();
    gf_t k, u, x2, z2, x3, z3, a, aa, b, bb, e, c, d, da, cb, t, inv, ex;
    bit  sw, kb;
    k = {scalar_copy[3], scalar_copy[2], scalar_copy[1], scalar_copy[0]};
    k[2:0] = 3'b000;
    k[255] = 1'b0;
    k[254] = 1'b1;
    u = {point_copy[3], point_copy[2], point_copy[1], point_copy[0]};
    u[255] = 1'b0;
    if (u >= x25_pkg::P) u = u - x25_pkg::P;
    x2 = 256'd1; z2 = 256'd0; x3 = u; z3 = 256'd1; sw = 0;
    for (int i = 254; i >= 0; i--) begin
      kb = k[i];
      if (sw ^ kb) begin
        t = x2; x2 = x3; x3 = t;
        t = z2; z2 = z3; z3 = t;
      end
      sw = kb;
      a  = gf_add(x2, z2);
      aa = gf_mul(a, a);
      b  = gf_sub(x2, z2);
      bb = gf_mul(b, b);
      e  = gf_sub(aa, bb);
      c  = gf_add(x3, z3);
      d  = gf_sub(x3, z3);
      da = gf_mul(d, a);
      cb = gf_mul(c, b);
      t  = gf_add(da, cb);
      x3 = gf_mul(t, t);
      t  = gf_sub(da, cb);
      z3 = gf_mul(gf_mul(t, t), u);
      x2 = gf_mul(aa, bb);
      z2 = gf_mul(gf_add(gf_mul(e, 256'd121665), aa), e);
    end
    if (sw) begin
      x2 = x3;
      z2 = z3;
    end
    // z^(p-2); zero stays zero, which yields the all-zero result
    ex = x25_pkg::P - 256'd2;
    inv = 256'd1;
    for (int i = 254; i >= 0; i--) begin
      inv = gf_mul(inv, inv);
      if (ex[i]) inv = gf_mul(inv, z2);
    end
    return gf_mul(x2, inv);
  endfunction

  // --- input side ----------------------------------------------------------
  // accept and predict at the rising edge
  always @(posedge clk) begin
    gf_t          res;
    secret_word_t sw_item;
    took <= !rst && in_valid && in_ready;
    if (!rst && in_valid && in_ready) begin
      scalar_copy[word_index] = scalar_word;
      point_copy[word_index] = point_word;
      if (word_index == x25_pkg::LAST_WORD) begin
        res = x25519_shared();
        for (int k = 0; k < 4; k++) begin
          sw_item.idx  = k[1:0];
          sw_item.word = res[64*k +: 64];
          sw_item.last = (k == 3);
          sw_item.zero = (res == '0);
          secret_q.push_back(sw_item);
        end
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 19);
    if (no_stall || r < 12) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(8, 60);
  endfunction

  // drive at the falling edge; valid holds until the transaction is taken
  always @(negedge clk) begin
    logic  nv;
    load_t ld;
    nv = in_valid;
    if (!rst && (!in_valid || took)) begin
      nv = 1'b0;
      if (send_gap > 0) begin
        send_gap--;
      end else if (load_q.size() > 0 &&
                   !(load_q[0].drain_first && secret_q.size() > 0)) begin
        ld = load_q.pop_front();
        word_index  <= ld.idx;
        scalar_word <= ld.scal;
        point_word  <= ld.pnt;
        nv = 1'b1;
        send_gap = pick_gap();
      end
    end
    in_valid <= nv;
    if ($urandom_range(0, 199) == 0) no_stall = !no_stall;
  end

  // --- output side ---------------------------------------------------------
  always @(negedge clk) begin
    if (recv_gap > 0) begin
      recv_gap--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      recv_gap = pick_gap();
    end
  end

  always @(posedge clk) begin
    secret_word_t want;
    if (!rst && out_valid && out_ready) begin
      if (secret_q.size() == 0) begin
        $error("unexpected result transaction: index %0d word %h", out_index, out_word);
        errors++;
      end else begin
        want = secret_q.pop_front();
        if (out_index !== want.idx) begin
          $error("out_index: expected %0d, got %0d", want.idx, out_index);
          errors++;
        end
        if (out_word !== want.word) begin
          $error("out_word: expected %h, got %h", want.word, out_word);
          errors++;
        end
        if (is_last !== want.last) begin
          $error("is_last: expected %0b, got %0b", want.last, is_last);
          errors++;
        end
        if (all_zero !== want.zero) begin
          $error("all_zero: expected %0b, got %0b", want.zero, all_zero);
          errors++;
        end
      end
    end
  end

  // --- stimulus --------------------------------------------------------------
  function automatic logic [63:0] rand_word();
    int r;
    r = $urandom_range(0, 15);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return {$urandom, $urandom};
  endfunction

  task automatic add_load(logic [1:0] idx, logic [63:0] s, logic [63:0] u,
                          bit drain = 0);
    load_t ld;
    ld.idx = idx;
    ld.scal = s;
    ld.pnt = u;
    ld.drain_first = drain;
    load_q.push_back(ld);
  endtask

  task automatic add_point(gf_t s, gf_t u, bit drain = 0);
    for (int k = 0; k < 4; k++)
      add_load(k[1:0], s[64*k +: 64], u[64*k +: 64], drain && k == 0);
  endtask

  initial begin
    gf_t base9;
    int  order[3];
    int  j, tmp;
    base9 = 256'd9;
    // directed: standard base point with all-ones scalar (clamp clears bits)
    add_point('1, base9);
    // zero scalar words, u with bit 255 set and the rest all ones (>= p)
    add_point('0, '1);
    // u = 0: low-order point, all-zero result
    add_point({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
               $urandom, $urandom}, '0);
    // u = p reduces to zero as well; then a repeated start reusing the words
    add_point({8{32'h5a5a_a5a5}}, x25_pkg::P, 1'b1);
    add_load(x25_pkg::LAST_WORD, 64'h8000_0000_0000_0007, 64'h0000_0000_0000_0001);
    // random: reordered well-formed loads with noise, then a start
    for (int n = 0; n < 7; n++) begin
      order = '{0, 1, 2};
      for (int a = 2; a > 0; a--) begin
        j = $urandom_range(0, a);
        tmp = order[a]; order[a] = order[j]; order[j] = tmp;
      end
      for (int a = 0; a < 3; a++)
        add_load(order[a][1:0], rand_word(), rand_word(), n == 3 && a == 0);
      repeat ($urandom_range(6, 9))
        add_load(2'($urandom_range(0, 2)), rand_word(), rand_word());
      add_load(x25_pkg::LAST_WORD, rand_word(), rand_word());
    end

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    wait (load_q.size() == 0 && !in_valid);
    wait (secret_q.size() == 0);
    repeat (200) @(posedge clk);
    if (errors == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

  // about 12 runs at a 4 ns clock period, with several times their expected time as margin
  initial begin
    #80_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

// File: files.f
+incdir+sv
sv/x25_pkg.sv
sv/x25_rf.sv
sv/x25_fu.sv
sv/x25_seq.sv
sv/x25519_scalar_multiply.sv
tb/sv/testbench.sv
